FILE: hdl/csvs_pkg.sv
// Shared constants, types and register indexes for the supported-value snapper.
`timescale 1ns / 1ps

package csvs_pkg;

    // Table geometry and value width.
    localparam int TABLE_ENTRIES  = 8;
    localparam int VALUE_BITS     = 16;
    localparam int SLOT_BITS      = 16;
    localparam int COUNT_BITS     = 4;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_MODE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_STEP  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_COUNT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_LOW   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_HIGH  = 3'd4;

    // Reduction tree shape: at least one registered level.
    localparam int TREE_LEVELS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;

    // Pipelined divider shape: a few quotient bits per stage.
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STAGES     = (VALUE_BITS + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_W          = DIV_STAGES * DIV_RADIX_BITS;

    // One node of the min, max and nearest-entry reduction tree.
    typedef struct packed {
        logic                  v;
        logic [VALUE_BITS-1:0] mn;
        logic [VALUE_BITS-1:0] mx;
        logic [VALUE_BITS-1:0] best;
        logic [VALUE_BITS-1:0] bestd;
    } node_t;

    // Request context that travels beside the divider.
    typedef struct packed {
        logic [VALUE_BITS-1:0] req;
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        logic [VALUE_BITS-1:0] best;
    } ctx_t;

endpackage

FILE: hdl/closest_supported_value_snap.sv
// Top level of the supported-value snapper: configuration, pipeline and output skid.
`timescale 1ns / 1ps

// Snaps each requested value to the closest value that the table allows.
// Input channel: in_valid, in_stall, requested_value. Output channel:
// out_valid, out_stall, snapped_value, table_empty. A beat moves on either
// channel at a rising edge where valid is high and stall is low.
// Configuration: cfg_valid, cfg_ready (always high), cfg_index, cfg_data;
// the user must see that registers are written only while no request is in
// flight; the block itself does not enforce it. Pipeline: a taken request
// passes through the input register, three tree levels for min, max and
// nearest entry, a prepare stage, eight divider stages of two quotient bits
// each, a rounding stage, a multiplier stage and the output register. Throughput:
// one request per cycle while not stalled; every stage is a full pipeline register.
// When the receiver stalls, the output register holds its beat and a one-beat
// skid register catches the next result; once the skid is full the whole
// pipeline freezes and in_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits and sets list mode, a step of one, an entry
// count of zero and an all-zero table.
module closest_supported_value_snap import csvs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [VALUE_BITS-1:0]     requested_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [VALUE_BITS-1:0]     snapped_value,
    output logic                      table_empty,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers.
    logic                     range_mode_reg;
    logic [VALUE_BITS-1:0]    range_step_reg;
    logic [COUNT_BITS-1:0]    entry_count_reg;
    logic [CFG_DATA_BITS-1:0] table_low_reg;
    logic [CFG_DATA_BITS-1:0] table_high_reg;

    logic [2*CFG_DATA_BITS-1:0]               table_all;
    logic [TABLE_ENTRIES-1:0][VALUE_BITS-1:0] entries;
    logic [TABLE_ENTRIES-1:0]                 entry_valid;
    logic [VALUE_BITS-1:0]                    divisor;
    logic                                     empty;

    // Pipeline advance.
    logic en;

    // Tree outputs.
    logic                  tree_valid;
    logic [VALUE_BITS-1:0] tree_req;
    node_t                 tree_node;

    // Prepare stage.
    logic                  prep_valid_reg;
    ctx_t                  prep_ctx_reg;
    logic [VALUE_BITS-1:0] prep_diff_reg;

    // Divider outputs.
    logic                  div_valid;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;
    ctx_t                  div_ctx;

    // Rounding stage.
    logic                  round_valid_reg;
    ctx_t                  round_ctx_reg;
    logic [VALUE_BITS-1:0] round_quo_reg;
    logic [VALUE_BITS-1:0] round_quo_next;

    // Multiplier stage.
    logic                    mul_valid_reg;
    ctx_t                    mul_ctx_reg;
    logic [VALUE_BITS-1:0]   mul_prod_reg;
    logic [2*VALUE_BITS-1:0] mul_full;

    // Final selection.
    logic                  res_valid;
    logic [VALUE_BITS-1:0] res_value;
    logic                  res_empty;

    // Output register and skid.
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_empty_reg;
    logic                  skid_valid_reg;
    logic [VALUE_BITS-1:0] skid_value_reg;
    logic                  skid_empty_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_mode_reg  <= 1'b0;
            range_step_reg  <= VALUE_BITS'(1);
            entry_count_reg <= '0;
            table_low_reg   <= '0;
            table_high_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RANGE_MODE:  range_mode_reg  <= cfg_data[0];
                REG_RANGE_STEP:  range_step_reg  <= cfg_data[VALUE_BITS-1:0];
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[COUNT_BITS-1:0];
                REG_TABLE_LOW:   table_low_reg   <= cfg_data;
                REG_TABLE_HIGH:  table_high_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Table slots and their valid flags; a count above the table size saturates.
    assign table_all = {table_high_reg, table_low_reg};

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_entry
        assign entries[gi]     = table_all[gi*SLOT_BITS +: VALUE_BITS];
        assign entry_valid[gi] = (entry_count_reg > COUNT_BITS'(gi));
    end

    assign empty   = (entry_count_reg == '0);
    assign divisor = (range_step_reg == '0) ? VALUE_BITS'(1) : range_step_reg;

    // The pipeline moves unless the skid register holds a beat.
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    csvs_tree u_tree
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .in_req      (requested_value),
        .entries     (entries),
        .entry_valid (entry_valid),
        .out_valid   (tree_valid),
        .out_req     (tree_req),
        .out_node    (tree_node)
    );

    // Prepare stage: gather the context and the offset above the minimum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= tree_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_ctx_reg.req  <= tree_req;
            prep_ctx_reg.lo   <= tree_node.mn;
            prep_ctx_reg.hi   <= tree_node.mx;
            prep_ctx_reg.best <= tree_node.best;
            prep_diff_reg     <= tree_req - tree_node.mn;
        end
    end

    csvs_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (prep_valid_reg),
        .in_dividend (prep_diff_reg),
        .divisor     (divisor),
        .in_ctx      (prep_ctx_reg),
        .out_valid   (div_valid),
        .quotient    (div_quo),
        .remainder   (div_rem),
        .out_ctx     (div_ctx)
    );

    // Rounding stage: halves round up.
    assign round_quo_next = ({div_rem, 1'b0} >= {1'b0, divisor})
                            ? div_quo + VALUE_BITS'(1) : div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            round_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            round_ctx_reg <= div_ctx;
            round_quo_reg <= round_quo_next;
        end
    end

    // Multiplier stage: only the low bits of the product reach the result.
    assign mul_full = round_quo_reg * divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_valid_reg <= round_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_ctx_reg  <= round_ctx_reg;
            mul_prod_reg <= mul_full[VALUE_BITS-1:0];
        end
    end

    // Final selection between empty, clamp, rounded range value and list entry.
    assign res_valid = mul_valid_reg;

    always_comb
    begin
        res_empty = 1'b0;
        if (empty)
        begin
            res_value = '0;
            res_empty = 1'b1;
        end
        else if (range_mode_reg)
        begin
            if (mul_ctx_reg.req > mul_ctx_reg.hi)
            begin
                res_value = mul_ctx_reg.hi;
            end
            else if (mul_ctx_reg.req < mul_ctx_reg.lo)
            begin
                res_value = mul_ctx_reg.lo;
            end
            else
            begin
                res_value = mul_ctx_reg.lo + mul_prod_reg;
            end
        end
        else
        begin
            res_value = mul_ctx_reg.best;
        end
    end

    // Output register with a one-beat skid behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (en && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_empty_reg <= skid_empty_reg;
            end
            else
            begin
                out_value_reg <= res_value;
                out_empty_reg <= res_empty;
            end
        end
        else if (en && res_valid)
        begin
            skid_value_reg <= res_value;
            skid_empty_reg <= res_empty;
        end
    end

    assign out_valid     = out_valid_reg;
    assign snapped_value = out_value_reg;
    assign table_empty   = out_empty_reg;

endmodule

FILE: hdl/csvs_tree.sv
// Input stage and registered reduction tree for table min, max and nearest entry.
`timescale 1ns / 1ps

module csvs_tree import csvs_pkg::*;
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic [VALUE_BITS-1:0]                    in_req,
    input  logic [TABLE_ENTRIES-1:0][VALUE_BITS-1:0] entries,
    input  logic [TABLE_ENTRIES-1:0]                 entry_valid,
    output logic                                     out_valid,
    output logic [VALUE_BITS-1:0]                    out_req,
    output node_t                                    out_node
);

    // Input stage registers.
    logic                  stage_valid_reg;
    logic [VALUE_BITS-1:0] stage_req_reg;

    // Tree nodes: index 1 is the root, children of k are 2k and 2k+1.
    node_t node_reg  [1:TREE_LEAVES-1];
    node_t node_next [1:TREE_LEAVES-1];
    node_t all_node  [1:2*TREE_LEAVES-1];
    node_t leaf      [TREE_LEAVES];

    // Request and valid bit delayed alongside the tree levels.
    logic                  side_valid_reg [TREE_LEVELS];
    logic [VALUE_BITS-1:0] side_req_reg   [TREE_LEVELS];

    // Merge two nodes; the left one has the lower index and wins ties.
    function automatic node_t merge(node_t a, node_t b);
        node_t m;
        m = a;
        if (!a.v) begin
            m = b;
        end else if (b.v) begin
            if (b.mn < a.mn) begin
                m.mn = b.mn;
            end
            if (b.mx > a.mx) begin
                m.mx = b.mx;
            end
            if (b.bestd < a.bestd) begin
                m.bestd = b.bestd;
                m.best  = b.best;
            end
        end
        return m;
    endfunction

    // Leaves: each entry with its absolute distance to the request.
    for (genvar gi = 0; gi < TREE_LEAVES; gi++) begin : g_leaf
        if (gi < TABLE_ENTRIES) begin : g_used
            assign leaf[gi].v     = entry_valid[gi];
            assign leaf[gi].mn    = entries[gi];
            assign leaf[gi].mx    = entries[gi];
            assign leaf[gi].best  = entries[gi];
            assign leaf[gi].bestd = (entries[gi] > stage_req_reg)
                                    ? entries[gi] - stage_req_reg
                                    : stage_req_reg - entries[gi];
        end else begin : g_pad
            assign leaf[gi] = '0;
        end
    end

    // Assemble the heap view and compute every node's next value.
    always_comb
    begin
        for (int k = 1; k < TREE_LEAVES; k++)
        begin
            all_node[k] = node_reg[k];
        end
        for (int i = 0; i < TREE_LEAVES; i++)
        begin
            all_node[TREE_LEAVES + i] = leaf[i];
        end
        for (int k = 1; k < TREE_LEAVES; k++)
        begin
            node_next[k] = merge(all_node[2*k], all_node[2*k + 1]);
        end
    end

    // Control: valid bits of the input stage and the side line.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            for (int j = 0; j < TREE_LEVELS; j++)
            begin
                side_valid_reg[j] <= 1'b0;
            end
        end
        else if (en)
        begin
            stage_valid_reg   <= in_valid;
            side_valid_reg[0] <= stage_valid_reg;
            for (int j = 1; j < TREE_LEVELS; j++)
            begin
                side_valid_reg[j] <= side_valid_reg[j-1];
            end
        end
    end

    // Payload: request, side line and tree nodes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_req_reg   <= in_req;
            side_req_reg[0] <= stage_req_reg;
            for (int j = 1; j < TREE_LEVELS; j++)
            begin
                side_req_reg[j] <= side_req_reg[j-1];
            end
            for (int k = 1; k < TREE_LEAVES; k++)
            begin
                node_reg[k] <= node_next[k];
            end
        end
    end

    assign out_valid = side_valid_reg[TREE_LEVELS-1];
    assign out_req   = side_req_reg[TREE_LEVELS-1];
    assign out_node  = node_reg[1];

endmodule

FILE: hdl/csvs_div.sv
// Pipelined restoring divider with a travelling request context.
`timescale 1ns / 1ps

module csvs_div import csvs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [VALUE_BITS-1:0] in_dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    input  ctx_t                  in_ctx,
    output logic                  out_valid,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder,
    output ctx_t                  out_ctx
);

    // Per stage: valid bit, partial remainder, dividend and quotient shift word.
    logic                  valid_reg [DIV_STAGES];
    logic [VALUE_BITS-1:0] rem_reg   [DIV_STAGES];
    logic [DIV_W-1:0]      work_reg  [DIV_STAGES];
    ctx_t                  ctx_reg   [DIV_STAGES];

    logic [VALUE_BITS-1:0] rem_next  [DIV_STAGES];
    logic [DIV_W-1:0]      work_next [DIV_STAGES];

    // Each stage retires DIV_RADIX_BITS quotient bits, most significant first.
    always_comb
    begin
        logic [VALUE_BITS:0]   sh;
        logic [VALUE_BITS-1:0] r;
        logic [DIV_W-1:0]      w;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                w = DIV_W'(in_dividend);
            end
            else
            begin
                r = rem_reg[s-1];
                w = work_reg[s-1];
            end
            for (int b = 0; b < DIV_RADIX_BITS; b++)
            begin
                sh = {r, w[DIV_W-1]};
                w  = {w[DIV_W-2:0], 1'b0};
                if (sh >= {1'b0, divisor})
                begin
                    sh   = sh - {1'b0, divisor};
                    w[0] = 1'b1;
                end
                r = sh[VALUE_BITS-1:0];
            end
            rem_next[s]  = r;
            work_next[s] = w;
        end
    end

    // Control: valid bits march with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                ctx_reg[s] <= ctx_reg[s-1];
            end
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                work_reg[s] <= work_next[s];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quotient  = work_reg[DIV_STAGES-1][VALUE_BITS-1:0];
    assign remainder = rem_reg[DIV_STAGES-1];
    assign out_ctx   = ctx_reg[DIV_STAGES-1];

endmodule

FILE: verif/tb_closest_supported_value_snap.sv
// Self-checking regression bench for the supported-value snapper.
`timescale 1ns / 1ps

module tb_closest_supported_value_snap;
    import csvs_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_PHASES = 14;
    localparam int HOLD_PHASE    = 5;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_FIRST = REG_TABLE_HIGH
                                                             + CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED_LAST  = '1;
    localparam logic [VALUE_BITS-1:0]     VALUE_MAX        = '1;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  empty;
    } snap_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;
    typedef enum int {SHAPE_SPREAD, SHAPE_CLUSTER, SHAPE_REPEATS, SHAPE_EXTREMES} shape_t;

    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      in_valid        = 1'b0;
    logic                      in_stall;
    logic [VALUE_BITS-1:0]     requested_value = '0;
    logic                      out_valid;
    logic                      out_stall       = 1'b0;
    logic [VALUE_BITS-1:0]     snapped_value;
    logic                      table_empty;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index       = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data        = '0;

    // Shadow copy of the configuration registers, at their reset values.
    logic                     shadow_range_mode = 1'b0;
    logic [VALUE_BITS-1:0]    shadow_step       = 1;
    logic [COUNT_BITS-1:0]    shadow_count      = '0;
    logic [CFG_DATA_BITS-1:0] shadow_tbl_low    = '0;
    logic [CFG_DATA_BITS-1:0] shadow_tbl_high   = '0;

    snap_t       pending_snaps[$];
    int          mismatch_count = 0;
    int          burst_left     = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;
    int          stall_tick     = 0;
    stall_mode_t stall_mode     = STALL_NONE;

    closest_supported_value_snap dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .requested_value (requested_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .snapped_value   (snapped_value),
        .table_empty     (table_empty),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [VALUE_BITS-1:0] table_entry(int i);
        logic [CFG_DATA_BITS-1:0] word;
        word = (i < 4) ? shadow_tbl_low : shadow_tbl_high;
        return word[(i % 4) * SLOT_BITS +: VALUE_BITS];
    endfunction

    // Counts above the table size are treated as a full table.
    function automatic int live_entries();
        return (shadow_count > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(shadow_count);
    endfunction

    function automatic int unsigned table_minimum();
        int unsigned lo;
        lo = table_entry(0);
        for (int i = 1; i < live_entries(); i++)
            if (table_entry(i) < lo)
                lo = table_entry(i);
        return lo;
    endfunction

    // Works out the snapped value for one request from the shadow registers.
    function automatic snap_t predict_snap(logic [VALUE_BITS-1:0] req);
        snap_t       res;
        int          n;
        int unsigned lo, hi, e, step, diff, quot, rem, best, best_dist, gap_to_req;
        n = live_entries();
        res.value = '0;
        res.empty = 1'b0;
        if (n == 0)
        begin
            res.empty = 1'b1;
            return res;
        end
        if (shadow_range_mode)
        begin
            lo = table_entry(0);
            hi = lo;
            for (int i = 1; i < n; i++)
            begin
                e = table_entry(i);
                if (e < lo) lo = e;
                if (e > hi) hi = e;
            end
            if (req > hi)
                res.value = VALUE_BITS'(hi);
            else if (req < lo)
                res.value = VALUE_BITS'(lo);
            else
            begin
                // A zero step behaves as a step of one; halves round up.
                step = (shadow_step == 0) ? 1 : shadow_step;
                diff = req - lo;
                quot = diff / step;
                rem  = diff % step;
                if (2 * rem >= step)
                    quot++;
                res.value = VALUE_BITS'(lo + quot * step);
            end
        end
        else
        begin
            // Nearest entry by absolute distance; the lowest index wins a tie.
            best      = table_entry(0);
            best_dist = (best > req) ? best - req : req - best;
            for (int i = 1; i < n; i++)
            begin
                e          = table_entry(i);
                gap_to_req = (e > req) ? e - req : req - e;
                if (gap_to_req < best_dist)
                begin
                    best_dist = gap_to_req;
                    best      = e;
                end
            end
            res.value = VALUE_BITS'(best);
        end
        return res;
    endfunction

    // Receiver stall pattern: picks a new random mode whenever the current one runs out.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    // Each result beat is checked against the oldest outstanding prediction.
    always @(posedge clk)
    begin : check_results
        snap_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_snaps.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result beat: value %h empty %b",
                             snapped_value, table_empty);
                mismatch_count++;
            end
            else
            begin
                want = pending_snaps.pop_front();
                if (snapped_value !== want.value || table_empty !== want.empty)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("mismatch: value exp %h got %h, empty exp %b got %b",
                                 want.value, snapped_value, want.empty, table_empty);
                    mismatch_count++;
                end
            end
        end
    end

    // The run is stopped when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("closest_supported_value_snap regression: fail");
            $finish;
        end
    end

    // Sends one request, in bursts of random length separated by random gaps.
    task automatic send_request(logic [VALUE_BITS-1:0] req);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid        <= 1'b1;
        requested_value <= req;
        do @(posedge clk); while (in_stall);
        pending_snaps = {pending_snaps, predict_snap(req)};
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_snaps.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RANGE_MODE:  shadow_range_mode = data[0];
            REG_RANGE_STEP:  shadow_step       = data[VALUE_BITS-1:0];
            REG_ENTRY_COUNT: shadow_count      = data[COUNT_BITS-1:0];
            REG_TABLE_LOW:   shadow_tbl_low    = data;
            REG_TABLE_HIGH:  shadow_tbl_high   = data;
            default: ;
        endcase
    endtask

    // Programs every register with the block idle; unused upper bits carry noise.
    task automatic apply_setting(logic mode, logic [VALUE_BITS-1:0] step,
                                 logic [COUNT_BITS-1:0] count,
                                 logic [CFG_DATA_BITS-1:0] tbl_low,
                                 logic [CFG_DATA_BITS-1:0] tbl_high);
        logic [CFG_DATA_BITS-1:0] word;
        wait_drained();
        word = {$urandom, $urandom};
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_UNUSED_LAST, REG_UNUSED_FIRST)), word);
        word    = {$urandom, $urandom};
        word[0] = mode;
        write_reg(REG_RANGE_MODE, word);
        word                   = {$urandom, $urandom};
        word[VALUE_BITS-1:0]   = step;
        write_reg(REG_RANGE_STEP, word);
        word                   = {$urandom, $urandom};
        word[COUNT_BITS-1:0]   = count;
        write_reg(REG_ENTRY_COUNT, word);
        write_reg(REG_TABLE_LOW, tbl_low);
        write_reg(REG_TABLE_HIGH, tbl_high);
        cfg_valid <= 1'b0;
    endtask

    // An empty table gives zero with the flag raised, in either mode.
    task automatic test_empty_table();
        apply_setting(1'b0, 1, 0, {$urandom, $urandom}, {$urandom, $urandom});
        send_request('0);
        send_request(VALUE_MAX);
        apply_setting(1'b1, 7, 0, {$urandom, $urandom}, {$urandom, $urandom});
        send_request(16'h1234);
    endtask

    // List mode: ties, duplicates, table extremes, oversized and single counts.
    task automatic test_list_mode();
        logic [CFG_DATA_BITS-1:0] tbl_low, tbl_high;
        tbl_low  = {16'd200, 16'd100, VALUE_MAX, 16'd0};
        tbl_high = {16'd8000, 16'd7000, 16'd5000, 16'd200};
        apply_setting(1'b0, 1, 8, tbl_low, tbl_high);
        send_request(16'd150);
        send_request('0);
        send_request(VALUE_MAX);
        send_request(16'd32768);
        send_request(16'd6000);
        send_request(16'd7500);
        apply_setting(1'b0, 1, 13, tbl_low, tbl_high);
        send_request(16'd65000);
        apply_setting(1'b0, 1, 1, tbl_low, tbl_high);
        send_request(16'd9999);
    endtask

    // Range mode: zero step, clamping, half-way rounding, rounding past max.
    task automatic test_range_mode();
        logic [CFG_DATA_BITS-1:0] tbl_low;
        tbl_low = {16'd0, 16'd2000, 16'd3000, 16'd1000};
        apply_setting(1'b1, 0, 3, tbl_low, '0);
        send_request(16'd1500);
        send_request(16'd1001);
        apply_setting(1'b1, 100, 3, tbl_low, '0);
        send_request(16'd1050);
        send_request(16'd1049);
        send_request(16'd500);
        send_request(16'd4000);
        apply_setting(1'b1, 700, 3, tbl_low, '0);
        send_request(16'd2990);
        // The largest step rounds beyond the 16-bit range and wraps.
        apply_setting(1'b1, VALUE_MAX, 2, {32'd0, VALUE_MAX, 16'd2}, '0);
        send_request(16'd40000);
        send_request(16'd30000);
        send_request('0);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 1;
            2:       return VALUE_MAX;
            3:       return VALUE_BITS'($urandom_range(2, 64));
            4:       return VALUE_BITS'($urandom_range(100, 5000));
            default: return VALUE_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [COUNT_BITS-1:0] random_count();
        int roll;
        roll = $urandom_range(0, 11);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return COUNT_BITS'($urandom_range(TABLE_ENTRIES + 1, 15));
        return COUNT_BITS'($urandom_range(1, TABLE_ENTRIES));
    endfunction

    // All eight entries; shapes favour near neighbours, repeats and extremes.
    function automatic logic [2*CFG_DATA_BITS-1:0] random_table();
        logic [2*CFG_DATA_BITS-1:0] tbl;
        int unsigned                base;
        shape_t                     shape;
        shape = shape_t'($urandom_range(0, 3));
        base  = $urandom_range(0, 65535);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            case (shape)
                SHAPE_SPREAD:
                    tbl[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom);
                SHAPE_CLUSTER:
                    tbl[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'(base + $urandom_range(0, 300));
                SHAPE_REPEATS:
                    tbl[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'(base + 50 * $urandom_range(0, 3));
                default:
                    case ($urandom_range(0, 2))
                        0:       tbl[i*SLOT_BITS +: SLOT_BITS] = '0;
                        1:       tbl[i*SLOT_BITS +: SLOT_BITS] = '1;
                        default: tbl[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom);
                    endcase
            endcase
        end
        return tbl;
    endfunction

    // Requests aimed at entries, midpoints, step boundaries and the extremes.
    function automatic logic [VALUE_BITS-1:0] random_request();
        int          roll, top;
        int unsigned a, b, step;
        roll = $urandom_range(0, 9);
        top  = (live_entries() == 0) ? 0 : live_entries() - 1;
        a    = table_entry($urandom_range(0, top));
        b    = table_entry($urandom_range(0, top));
        step = (shadow_step == 0) ? 1 : shadow_step;
        if (roll < 4)
            return VALUE_BITS'($urandom);
        else if (roll < 7)
            return VALUE_BITS'(a + $urandom_range(0, 8) - 4);
        else if (roll == 7)
            return VALUE_BITS'((a + b) / 2 + $urandom_range(0, 2) - 1);
        else if (roll == 8)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return VALUE_MAX;
                2:       return 1;
                default: return VALUE_MAX - 1;
            endcase
        end
        return VALUE_BITS'(table_minimum() + $urandom_range(0, 4) * step + step / 2
                           - $urandom_range(0, 1));
    endfunction

    // Random settings and requests, with the extreme settings pinned early on.
    task automatic test_random_phases();
        logic                       mode;
        logic [VALUE_BITS-1:0]      step;
        logic [COUNT_BITS-1:0]      count;
        logic [2*CFG_DATA_BITS-1:0] tbl;
        int                         items;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            mode  = 1'($urandom_range(0, 1));
            step  = random_step();
            count = random_count();
            tbl   = random_table();
            case (p)
                0: begin mode = 1'b1; step = '0; end
                1: begin mode = 1'b1; step = VALUE_MAX; count = COUNT_BITS'(TABLE_ENTRIES); end
                2: begin mode = 1'b0; count = '1; end
                3: begin mode = 1'b1; step = 1; end
                default: ;
            endcase
            apply_setting(mode, step, count, tbl[CFG_DATA_BITS-1:0],
                          tbl[2*CFG_DATA_BITS-1:CFG_DATA_BITS]);
            items = $urandom_range(95, 120);
            for (int k = 0; k < items; k++)
            begin
                // Once, the sender stops mid-phase until the pipeline has emptied.
                if (p == HOLD_PHASE && k == items / 2)
                    wait_drained();
                send_request(random_request());
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_list_mode();
        test_range_mode();
        test_random_phases();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_snaps.size() == 0)
            $display("closest_supported_value_snap regression: pass");
        else
            $display("closest_supported_value_snap regression: fail");
        $finish;
    end

endmodule
